@@ hdl/bmsc_pkg.sv @@
// Shared constants, types and codes for the best-match string classifier.
// No dependencies; every other file imports this package.
package bmsc_pkg;

  localparam int BANKS     = 4;
  localparam int ENTRIES   = 64;
  localparam int MSG_LEN   = 32;
  localparam int CFG_BANKS = 4;

  localparam int SRCH_BANKS = (BANKS < CFG_BANKS) ? BANKS : CFG_BANKS;
  localparam int ROWS       = BANKS * ENTRIES;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BANK_W     = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int ENT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ENT_CW     = $clog2(ENTRIES + 1);
  localparam int SB_W       = $clog2(SRCH_BANKS + 1);
  localparam int CB_W       = $clog2(CFG_BANKS);
  localparam int POS_W      = $clog2(MSG_LEN);
  localparam int QLEN_W     = $clog2(MSG_LEN + 1);
  localparam int SC_W       = QLEN_W;
  localparam int NGRP       = 8;
  localparam int GRP_W      = (MSG_LEN + NGRP - 1) / NGRP;
  localparam int GC_W       = $clog2(GRP_W + 1);

  // Fixed field widths of the channels and the config port
  localparam int CMD_W      = 1;
  localparam int IN_BANK_W  = 2;
  localparam int IN_ENT_W   = 6;
  localparam int IN_POS_W   = 5;
  localparam int CHAR_W     = 8;
  localparam int OUT_BANK_W = 2;
  localparam int OUT_ENT_W  = 6;
  localparam int OUT_SC_W   = 6;
  localparam int MIN_W      = 6;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CMD_W-1:0] CMD_TMPL  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCORE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK0_ENTRIES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK1_ENTRIES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK2_ENTRIES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK3_ENTRIES = 3'd4;

  localparam logic [MIN_W-1:0] MIN_SCORE_RST = 6'd6;
  localparam logic [CNT_W-1:0] ENT_RST [CFG_BANKS] = '{7'd37, 7'd40, 7'd23, 7'd26};

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [MSG_LEN-1:0][CHAR_W-1:0] row_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [ENT_W-1:0]  entry;
  } tag_t;

  typedef struct packed {
    logic             vld;
    logic             busy;
    logic [SC_W-1:0]  score;
    tag_t             tag;
  } score_res_t;

endpackage

@@ hdl/bmsc_in_if.sv @@
// Input channel of the classifier: valid/ready plus one command item.
// Depends on bmsc_pkg for field widths.
interface bmsc_in_if;
  import bmsc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [IN_BANK_W-1:0] bank;
  logic [IN_ENT_W-1:0]  entry;
  logic [IN_POS_W-1:0]  position;
  logic [CHAR_W-1:0]    char_code;
  logic                 last;

  modport source (output valid, command, bank, entry, position, char_code, last,
                  input ready);
  modport sink   (input valid, command, bank, entry, position, char_code, last,
                  output ready);
endinterface

@@ hdl/bmsc_out_if.sv @@
// Result channel of the classifier: valid/ready plus one match result.
// Depends on bmsc_pkg for field widths.
interface bmsc_out_if;
  import bmsc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  match_found;
  logic [OUT_BANK_W-1:0] matched_bank;
  logic [OUT_ENT_W-1:0]  matched_entry;
  logic [OUT_SC_W-1:0]   top_score;

  modport source (output valid, match_found, matched_bank, matched_entry, top_score,
                  input ready);
  modport sink   (input valid, match_found, matched_bank, matched_entry, top_score,
                  output ready);
endinterface

@@ hdl/bmsc_tmpl_mem.sv @@
// Template store: one row per template, one byte lane per character.
// Row valid bits stand in for a reset clear. Depends on bmsc_pkg.
module bmsc_tmpl_mem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [bmsc_pkg::ROW_W-1:0] wr_row,
  input  logic [bmsc_pkg::POS_W-1:0] wr_pos,
  input  bmsc_pkg::char_t      wr_char,
  input  logic                 rd_en,
  input  logic [bmsc_pkg::ROW_W-1:0] rd_row,
  output bmsc_pkg::row_t       rd_data
);
  import bmsc_pkg::*;

  row_t            mem [ROWS];
  logic [ROWS-1:0] row_vld_r;
  row_t            rd_data_r;
  logic            rd_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_row] <= 1'b1;
    end
  end

  // First write to a row fills the rest of it with zeros.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < MSG_LEN; k++) begin
        if (!row_vld_r[wr_row] || k == int'(wr_pos)) begin
          mem[wr_row][k] <= (k == int'(wr_pos)) ? wr_char : '0;
        end
      end
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
      rd_hit_r  <= row_vld_r[rd_row];
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

@@ hdl/bmsc_score.sv @@
// Query buffer and the scoring pipeline: one template row in per cycle,
// one score out per cycle, four register stages. Depends on bmsc_pkg.
module bmsc_score (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_we,
  input  logic [bmsc_pkg::POS_W-1:0]  q_pos,
  input  bmsc_pkg::char_t             q_char,
  input  logic [bmsc_pkg::QLEN_W-1:0] qlen,
  input  logic                        issue_vld,
  input  bmsc_pkg::tag_t              issue_tag,
  input  bmsc_pkg::row_t              row,
  output bmsc_pkg::score_res_t        res
);
  import bmsc_pkg::*;

  char_t qbuf_r [MSG_LEN];

  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  tag_t tag0_r, tag1_r, tag2_r, tag3_r, tag4_r;

  logic [MSG_LEN-1:0]   z1_r, eq1_r, z1_nxt, eq1_nxt;
  logic [MSG_LEN-1:0]   hit2_r, hit2_nxt;
  logic [MSG_LEN-1:0]   lowbit, live;
  logic [GC_W-1:0]      grp3_r [NGRP];
  logic [GC_W-1:0]      grp3_nxt [NGRP];
  logic [NGRP*GRP_W-1:0] hit_pad;
  logic [SC_W-1:0]      score4_r, score4_nxt;

  always_ff @(posedge clk) begin
    if (q_we) begin
      qbuf_r[q_pos] <= q_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v0_r, v1_r, v2_r, v3_r, v4_r} <= '0;
    end else begin
      {v0_r, v1_r, v2_r, v3_r, v4_r} <= {issue_vld, v0_r, v1_r, v2_r, v3_r};
    end
  end

  // Stage 1: stop flags and equal flags per lane
  always_comb begin
    for (int i = 0; i < MSG_LEN; i++) begin
      z1_nxt[i]  = (qbuf_r[i] == '0) || (row[i] == '0) || (QLEN_W'(i) >= qlen);
      eq1_nxt[i] = (qbuf_r[i] == row[i]);
    end
  end

  // Stage 2: lanes below the lowest stop flag count
  assign lowbit   = z1_r & (~z1_r + MSG_LEN'(1));
  assign live     = lowbit - MSG_LEN'(1);
  assign hit2_nxt = live & eq1_r;

  // Stage 3: per-group counts; stage 4: group sum
  assign hit_pad = (NGRP*GRP_W)'(hit2_r);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp3_nxt[g] = '0;
      for (int b = 0; b < GRP_W; b++) begin
        grp3_nxt[g] = grp3_nxt[g] + GC_W'(hit_pad[g*GRP_W + b]);
      end
    end
  end

  always_comb begin
    score4_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      score4_nxt = score4_nxt + SC_W'(grp3_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    tag0_r   <= issue_tag;
    tag1_r   <= tag0_r;
    tag2_r   <= tag1_r;
    tag3_r   <= tag2_r;
    tag4_r   <= tag3_r;
    z1_r     <= z1_nxt;
    eq1_r    <= eq1_nxt;
    hit2_r   <= hit2_nxt;
    grp3_r   <= grp3_nxt;
    score4_r <= score4_nxt;
  end

  assign res.vld   = v4_r;
  assign res.busy  = v0_r | v1_r | v2_r | v3_r | v4_r;
  assign res.score = score4_r;
  assign res.tag   = tag4_r;

endmodule

@@ hdl/best_match_string_classifier_top.sv @@
// Best-match string classifier. Template and query characters each take one
// transfer. A query transfer with last set starts a search that reads one
// 32-byte template row per cycle from the template memory, bank by bank over
// the searched entries, then drains the scoring pipeline and loads the result.
// Inputs are held off during a search; the result waits in an output register,
// and a search that ends while that register is still full waits for it to drain.
// The template store is empty right after reset; no clearing pass is needed.
module best_match_string_classifier_top (
  input  logic                           clk,
  input  logic                           rst_n,
  bmsc_in_if.sink                        in_ch,
  bmsc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [bmsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bmsc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [MIN_W-1:0]  min_r;
  logic [CNT_W-1:0]  cfg_ent_r [CFG_BANKS];
  logic [SB_W-1:0]   scan_bank_r, scan_bank_nxt;
  logic [ENT_CW-1:0] scan_ent_r, scan_ent_nxt, ent_lim;
  logic [CNT_W-1:0]  ent_cnt;
  logic [QLEN_W-1:0] qlen_r;
  logic [SC_W-1:0]   best_r;
  tag_t              best_tag_r;

  logic              out_vld_r, out_found_r;
  logic [OUT_BANK_W-1:0] out_bank_r;
  logic [OUT_ENT_W-1:0]  out_entry_r;
  logic [OUT_SC_W-1:0]   out_score_r;

  logic acc, is_q, pos_ok, tmpl_ok, start, rd_issue, out_load, found;
  logic [ROW_W-1:0]  wr_row, rd_row;
  logic [POS_W-1:0]  pos_idx;
  tag_t              issue_tag;
  row_t              rd_data;
  score_res_t        sres;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc     = in_ch.valid & in_ch.ready;
  assign is_q    = (in_ch.command == CMD_QUERY);
  assign pos_ok  = 7'(in_ch.position) < 7'(MSG_LEN);
  assign tmpl_ok = (4'(in_ch.bank) < 4'(BANKS)) && (9'(in_ch.entry) < 9'(ENTRIES));
  assign start   = acc & is_q & in_ch.last;
  assign pos_idx = POS_W'(in_ch.position);
  assign wr_row  = ROW_W'(int'(in_ch.bank) * ENTRIES + int'(in_ch.entry));

  // Entry limit of the bank being scanned, clipped to the bank depth
  assign ent_cnt = cfg_ent_r[CB_W'(scan_bank_r)];
  assign ent_lim = (9'(ent_cnt) > 9'(ENTRIES)) ? ENT_CW'(ENTRIES) : ENT_CW'(ent_cnt);

  assign rd_issue        = (state_r == ST_SCAN) && (scan_ent_r < ent_lim);
  assign issue_tag.bank  = BANK_W'(scan_bank_r);
  assign issue_tag.entry = scan_ent_r[ENT_W-1:0];
  assign rd_row          = ROW_W'(int'(issue_tag.bank) * ENTRIES + int'(issue_tag.entry));

  bmsc_tmpl_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (acc & ~is_q & tmpl_ok & pos_ok),
    .wr_row  (wr_row),
    .wr_pos  (pos_idx),
    .wr_char (in_ch.char_code),
    .rd_en   (rd_issue),
    .rd_row  (rd_row),
    .rd_data (rd_data)
  );

  bmsc_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_we      (acc & is_q & pos_ok),
    .q_pos     (pos_idx),
    .q_char    (in_ch.char_code),
    .qlen      (qlen_r),
    .issue_vld (rd_issue),
    .issue_tag (issue_tag),
    .row       (rd_data),
    .res       (sres)
  );

  assign out_load = (state_r == ST_FIN) && (!out_vld_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    scan_bank_nxt = scan_bank_r;
    scan_ent_nxt  = scan_ent_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt     = ST_SCAN;
          scan_bank_nxt = '0;
          scan_ent_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (scan_ent_r < ent_lim) begin
          scan_ent_nxt = scan_ent_r + ENT_CW'(1);
        end else if (scan_bank_r == SB_W'(SRCH_BANKS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_bank_nxt = scan_bank_r + SB_W'(1);
          scan_ent_nxt  = '0;
        end
      end
      ST_DRAIN: begin
        if (!sres.busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      min_r     <= MIN_SCORE_RST;
      cfg_ent_r <= ENT_RST;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_SCORE:     min_r        <= cfg_data[MIN_W-1:0];
          CFG_BANK0_ENTRIES: cfg_ent_r[0] <= cfg_data;
          CFG_BANK1_ENTRIES: cfg_ent_r[1] <= cfg_data;
          CFG_BANK2_ENTRIES: cfg_ent_r[2] <= cfg_data;
          CFG_BANK3_ENTRIES: cfg_ent_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Winner needs a nonzero score; strict compare keeps the earliest on ties
  assign found = (best_r != '0) && (8'(best_r) >= 8'(min_r));

  always_ff @(posedge clk) begin
    scan_bank_r <= scan_bank_nxt;
    scan_ent_r  <= scan_ent_nxt;
    if (start) begin
      qlen_r     <= pos_ok ? QLEN_W'(in_ch.position) + QLEN_W'(1) : QLEN_W'(MSG_LEN);
      best_r     <= '0;
      best_tag_r <= '0;
    end else if (sres.vld && sres.score > best_r) begin
      best_r     <= sres.score;
      best_tag_r <= sres.tag;
    end
    if (out_load) begin
      out_found_r <= found;
      out_bank_r  <= found ? OUT_BANK_W'(best_tag_r.bank) : '0;
      out_entry_r <= found ? OUT_ENT_W'(best_tag_r.entry) : '0;
      out_score_r <= (8'(best_r) > 8'd63) ? 6'd63 : OUT_SC_W'(best_r);
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.match_found   = out_found_r;
  assign out_ch.matched_bank  = out_bank_r;
  assign out_ch.matched_entry = out_entry_r;
  assign out_ch.top_score     = out_score_r;

`ifndef SYNTHESIS
  a_score_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    sres.vld |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("score arrived outside a search");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_issue |-> (scan_bank_r < SB_W'(SRCH_BANKS) && scan_ent_r < ENT_CW'(ENTRIES)))
    else $error("row read outside the searched range");

  a_found_score: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_found_r) |-> (out_score_r != '0 && out_score_r >= min_r))
    else $error("match reported below minimum score");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_vld_r && state_r == ST_IDLE))
    else $error("result not presented after search end");
`endif

endmodule

@@ sim/best_match_string_classifier_top_tb.sv @@
// Testbench for best_match_string_classifier_top: directed and random template/query
// traffic with random stalls, results checked against a behavioral template search.
// Depends on bmsc_pkg, bmsc_in_if, bmsc_out_if and the classifier top module.
module best_match_string_classifier_top_tb;
  import bmsc_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [IN_BANK_W-1:0] bank;
    logic [IN_ENT_W-1:0]  entry;
    logic [IN_POS_W-1:0]  position;
    logic [CHAR_W-1:0]    char_code;
    logic                 last;
  } cmd_item_t;

  typedef struct packed {
    logic                  match_found;
    logic [OUT_BANK_W-1:0] matched_bank;
    logic [OUT_ENT_W-1:0]  matched_entry;
    logic [OUT_SC_W-1:0]   top_score;
  } match_t;

  // Mirror of the template store, query buffer and registers, plus the queue of
  // search results still owed by the block.
  class nearest_match_board;
    bit [CHAR_W-1:0] rows [BANKS][ENTRIES][MSG_LEN];
    bit [CHAR_W-1:0] query [MSG_LEN];
    bit [MIN_W-1:0]  min_score;
    bit [CNT_W-1:0]  bank_count [CFG_BANKS];
    match_t          awaited_matches [$];
    int              errors;

    function new();
      min_score = MIN_SCORE_RST;
      foreach (bank_count[i]) bank_count[i] = ENT_RST[i];
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_SCORE:     min_score = data[MIN_W-1:0];
        CFG_BANK0_ENTRIES: bank_count[0] = data;
        CFG_BANK1_ENTRIES: bank_count[1] = data;
        CFG_BANK2_ENTRIES: bank_count[2] = data;
        CFG_BANK3_ENTRIES: bank_count[3] = data;
        default: ;
      endcase
    endfunction

    function int row_score(int b, int e, int qlen);
      int s;
      s = 0;
      for (int i = 0; i < qlen; i++) begin
        if (query[i] == 0 || rows[b][e][i] == 0) break;
        if (query[i] == rows[b][e][i]) s++;
      end
      return s;
    endfunction

    function void note_transfer(cmd_item_t it);
      int qlen, n, s, best, best_b, best_e;
      match_t m;
      if (it.command == CMD_TMPL) begin
        rows[it.bank][it.entry][it.position] = it.char_code;
        return;
      end
      query[it.position] = it.char_code;
      if (!it.last) return;
      qlen = it.position + 1;
      best = 0;
      best_b = 0;
      best_e = 0;
      for (int b = 0; b < SRCH_BANKS; b++) begin
        n = (bank_count[b] > ENTRIES) ? ENTRIES : bank_count[b];
        for (int e = 0; e < n; e++) begin
          s = row_score(b, e, qlen);
          // strict compare: ties stay with the earlier bank/entry
          if (s > best) begin
            best = s;
            best_b = b;
            best_e = e;
          end
        end
      end
      // best == 0 means no winner, even with min_score == 0
      m.match_found   = (best > 0) && (best >= min_score);
      m.matched_bank  = m.match_found ? OUT_BANK_W'(best_b) : '0;
      m.matched_entry = m.match_found ? OUT_ENT_W'(best_e) : '0;
      m.top_score     = (best > 63) ? OUT_SC_W'(63) : OUT_SC_W'(best);
      awaited_matches.push_back(m);
    endfunction

    function void check_match(match_t got);
      match_t want;
      if (awaited_matches.size() == 0) begin
        $error("unexpected result: match_found=%0d bank=%0d entry=%0d score=%0d",
               got.match_found, got.matched_bank, got.matched_entry, got.top_score);
        errors++;
        return;
      end
      want = awaited_matches.pop_front();
      if (got.match_found !== want.match_found) begin
        $error("match_found: expected %0d, got %0d", want.match_found, got.match_found);
        errors++;
      end
      if (got.matched_bank !== want.matched_bank) begin
        $error("matched_bank: expected %0d, got %0d", want.matched_bank, got.matched_bank);
        errors++;
      end
      if (got.matched_entry !== want.matched_entry) begin
        $error("matched_entry: expected %0d, got %0d", want.matched_entry, got.matched_entry);
        errors++;
      end
      if (got.top_score !== want.top_score) begin
        $error("top_score: expected %0d, got %0d", want.top_score, got.top_score);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bmsc_in_if  in_ch();
  bmsc_out_if out_ch();

  best_match_string_classifier_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nearest_match_board board;
  bit                 calm = 1'b0;
  bit                 hold_req = 1'b0;
  int                 hold_cycles = 0;
  int                 sent = 0;
  bit [MSG_LEN-1:0]   q_known = '0;
  bit [CHAR_W-1:0]    recent [MSG_LEN];
  int                 recent_len = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      board.note_transfer({in_ch.command, in_ch.bank, in_ch.entry, in_ch.position,
                           in_ch.char_code, in_ch.last});
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_match({out_ch.match_found, out_ch.matched_bank, out_ch.matched_entry,
                         out_ch.top_score});
  end

  // result side: random stalls, or a long hold-off when requested
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cycles = 600;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 28);
      end
    end
  end

  function automatic int pick_char();
    // small alphabet so templates and queries agree often
    if ($urandom_range(99) < 80) return 8'h61 + $urandom_range(3);
    return $urandom_range(255, 1);
  endfunction

  // returns at the edge where the transfer happened, valid still high
  task automatic send_item(logic [CMD_W-1:0] cmd, int b, int e, int p, int ch, bit lst);
    while (!calm && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.bank      <= IN_BANK_W'(b);
    in_ch.entry     <= IN_ENT_W'(e);
    in_ch.position  <= IN_POS_W'(p);
    in_ch.char_code <= CHAR_W'(ch);
    in_ch.last      <= lst;
    if (cmd == CMD_QUERY) q_known[p] = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.awaited_matches.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(int min_s, int n0, int n1, int n2, int n3);
    int                   vals [5];
    logic [CFG_IDX_W-1:0] idx [5];
    vals = '{min_s, n0, n1, n2, n3};
    idx  = '{CFG_MIN_SCORE, CFG_BANK0_ENTRIES, CFG_BANK1_ENTRIES, CFG_BANK2_ENTRIES,
             CFG_BANK3_ENTRIES};
    quiesce();
    foreach (vals[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
      board.set_register(idx[i], CFG_DATA_W'(vals[i]));
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int phase_start, pick, b, e, len, p, ch;
    bit hold_done, paused, lst;
    board = new();
    hold_done = 1'b0;
    paused = 1'b0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_MIN_SCORE;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_TMPL;
    in_ch.bank      <= '0;
    in_ch.entry     <= '0;
    in_ch.position  <= '0;
    in_ch.char_code <= '0;
    in_ch.last      <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two equal templates: the tie goes to bank 0 once the threshold allows a match
    send_item(CMD_TMPL, 0, 0, 0, 8'h41, 1'b0);
    send_item(CMD_TMPL, 0, 0, 1, 8'h42, 1'b0);
    send_item(CMD_TMPL, 1, 5, 0, 8'h41, 1'b0);
    send_item(CMD_TMPL, 1, 5, 1, 8'h42, 1'b0);
    send_item(CMD_TMPL, 3, 63, 31, 8'hFF, 1'b1);   // last is ignored on template writes
    send_item(CMD_QUERY, 0, 0, 0, 8'h41, 1'b0);
    send_item(CMD_QUERY, 0, 0, 1, 8'h42, 1'b1);
    send_item(CMD_QUERY, 0, 0, 2, 8'h43, 1'b0);
    send_item(CMD_QUERY, 0, 0, 0, 8'h41, 1'b1);    // stale data at positions 1..2 not scored
    send_item(CMD_QUERY, 3, 63, 1, 8'h00, 1'b1);
    send_item(CMD_QUERY, 0, 0, 0, 8'h00, 1'b1);    // empty query
    // exact six-char hit right at the reset threshold
    for (int i = 0; i < 6; i++) send_item(CMD_TMPL, 2, 22, i, 8'h67 + i, 1'b0);
    for (int i = 0; i < 6; i++) send_item(CMD_QUERY, 0, 0, i, 8'h67 + i, i == 5);

    configure(0, 37, 40, 23, 26);
    send_item(CMD_QUERY, 0, 0, 0, 8'h00, 1'b1);    // no winner even with threshold 0
    send_item(CMD_QUERY, 0, 0, 0, 8'h41, 1'b1);

    for (int k = 0; k < 10; k++) begin
      case (k)
        0: configure(0, ENTRIES, ENTRIES, ENTRIES, ENTRIES);
        1: configure(32, 0, 0, 0, 0);
        2: configure(63, 127, 100, 65, ENTRIES);   // counts above ENTRIES clamp
        default: begin
          configure(($urandom_range(99) < 80) ? $urandom_range(8) : $urandom_range(32),
                    $urandom_range(64), $urandom_range(64), $urandom_range(64),
                    $urandom_range(64));
        end
      endcase
      calm = (k == 4);
      phase_start = sent;
      while (sent - phase_start < 104) begin
        if (k == 5 && !hold_done && sent - phase_start >= 20) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        if (k == 6 && !paused && sent - phase_start >= 50) begin
          quiesce();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 42) begin
          // template string, zero-terminated so older content is cut off
          b = $urandom_range(3);
          e = ($urandom_range(99) < 85) ? $urandom_range(15) : $urandom_range(63);
          len = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(32, 1);
          for (int i = 0; i < len; i++) begin
            recent[i] = CHAR_W'(pick_char());
            send_item(CMD_TMPL, b, e, i, recent[i], $urandom_range(99) < 10);
          end
          if (len < MSG_LEN) send_item(CMD_TMPL, b, e, len, 8'h00, 1'b0);
          recent_len = len;
        end else if (pick < 80) begin
          // query, mostly a mutated copy of the latest template
          len = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(32, 1);
          for (int i = 0; i < len; i++) begin
            ch = (i < recent_len && $urandom_range(99) < 75) ? recent[i] : pick_char();
            if ($urandom_range(99) < 3) ch = 0;
            send_item(CMD_QUERY, $urandom_range(3), $urandom_range(63), i, ch, i == len - 1);
          end
        end else begin
          // lone random item; a search never reads unwritten query positions
          p = $urandom_range(31);
          lst = 1'($urandom_range(1));
          if (pick < 90 && lst) begin
            for (int i = 0; i < p; i++)
              if (!q_known[i]) send_item(CMD_QUERY, 0, 0, i, pick_char(), 1'b0);
          end
          send_item((pick < 90) ? CMD_QUERY : CMD_TMPL, $urandom_range(3), $urandom_range(63),
                    p, $urandom_range(255), lst);
        end
      end
    end

    calm = 1'b0;
    quiesce();
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.awaited_matches.size() == 0) begin
      $display("PASS best_match_string_classifier_top");
    end else begin
      $display("FAIL best_match_string_classifier_top");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL best_match_string_classifier_top");
    $finish;
  end

endmodule
